// File: rtl/core/i2cmbs_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared types and constants: item kinds, command codes, phase codes and the
// phase delays in microseconds.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

    // Item kinds.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Command codes. Codes six and seven mean nothing and are ignored.
    typedef enum logic [2:0] {
        OP_INIT  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5
    } t_op;

    // Phase codes within one command; their meaning depends on the command.
    typedef enum logic [3:0] {
        PH_0 = 4'd0,
        PH_1 = 4'd1,
        PH_2 = 4'd2,
        PH_3 = 4'd3,
        PH_4 = 4'd4,
        PH_5 = 4'd5
    } t_phase;

    // Widths of state fields.
    localparam int unsigned US_W   = 6;
    localparam int unsigned BIT_W  = 4;

    // Reset value of the ticks per microsecond register.
    localparam logic [7:0] TPU_RESET = 8'd8;

    // Last bit index of a byte.
    localparam logic [BIT_W-1:0] LAST_BIT = 4'd7;

    // Phase delays in microseconds.
    localparam logic [US_W-1:0] DLY_INIT = 6'd50;
    localparam logic [US_W-1:0] DLY_5    = 6'd5;
    localparam logic [US_W-1:0] DLY_4    = 6'd4;
    localparam logic [US_W-1:0] DLY_3    = 6'd3;
    localparam logic [US_W-1:0] DLY_2    = 6'd2;
    localparam logic [US_W-1:0] DLY_1    = 6'd1;

endpackage

// File: rtl/core/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Open-drain I2C master that walks SCL and SDA through timed phases. Items are
// ticks carrying the sampled SDA level, or commands (init, start, stop, write
// byte, read byte, send ack bit).
//
//   Channel  Direction  Handshake              Payload
//   in       input      i_in_valid/o_in_stall  kind, op, tx_byte, ack_bit, sda_in
//   out      output     o_out_valid/i_out_stall scl, sda, busy, done, ack, rx, rej
//   cfg      input      i_cfg_valid/o_cfg_ready ticks_per_us (8 bit)
//
// Each request passes an input register and a result register: its result is
// valid once it has moved from the input register into the result register,
// and one request is taken every cycle while the output does not stall.
// The sequencer state is updated in the same cycle the input register moves
// into the result register. Reset is synchronous, clears the valid bits of
// both registers and resets all sequencer state. A stall on the output holds the
// result register, then the input register, then pushes back on the input.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Item channel.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [2:0] i_op,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_bit,
    input  logic       i_sda_in,
    // Result channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_ack_received,
    output logic [7:0] o_rx_byte,
    output logic       o_rejected,
    // Configuration channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam int unsigned US_W  = i2cmbs_pkg::US_W;
    localparam int unsigned BIT_W = i2cmbs_pkg::BIT_W;

    // Configuration register.
    logic [7:0] r_tpu;

    // Input register.
    logic       r_in_valid;
    logic       r_in_kind;
    logic [2:0] r_in_op;
    logic [7:0] r_in_tx;
    logic       r_in_ack;
    logic       r_in_sda;

    // Sequencer state.
    logic [2:0]       r_active_op, n_active_op;
    logic [3:0]       r_phase, n_phase;
    logic [BIT_W-1:0] r_bit_idx, n_bit_idx;
    logic [7:0]       r_shift, n_shift;
    logic [US_W-1:0]  r_us_left, n_us_left;
    logic [7:0]       r_sub, n_sub;
    logic             r_scl, n_scl;
    logic             r_sda, n_sda;
    logic             r_busy, n_busy;
    logic             r_ack_flag, n_ack_flag;
    logic [7:0]       r_read_res, n_read_res;

    // Result register.
    logic r_out_valid;
    logic r_res_done, n_done;
    logic r_res_rej, n_rej;

    // Pipeline control.
    logic w_adv;
    logic w_in_take;

    // Tick arithmetic.
    logic [7:0]      w_rate;
    logic [7:0]      w_sub_inc;
    logic [US_W-1:0] w_us_dec;
    logic [7:0]      w_shift_up;
    logic            w_fin;

    // Move from the input register to the result register when it can drain.
    assign w_adv     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_take = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu <= i2cmbs_pkg::TPU_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tpu <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_kind <= i_kind;
            r_in_op   <= i_op;
            r_in_tx   <= i_tx_byte;
            r_in_ack  <= i_ack_bit;
            r_in_sda  <= i_sda_in;
        end
    end

    // Microsecond timebase: a zero rate counts as one tick per microsecond.
    assign w_rate     = (r_tpu == 8'd0) ? 8'd1 : r_tpu;
    assign w_sub_inc  = r_sub + 8'd1;
    assign w_us_dec   = (r_us_left != '0) ? (r_us_left - US_W'(1)) : r_us_left;
    assign w_shift_up = {r_shift[6:0], 1'b0};

    // Next sequencer state for the request leaving the input register.
    always_comb begin
        n_active_op = r_active_op;
        n_phase     = r_phase;
        n_bit_idx   = r_bit_idx;
        n_shift     = r_shift;
        n_us_left   = r_us_left;
        n_sub       = r_sub;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_busy      = r_busy;
        n_ack_flag  = r_ack_flag;
        n_read_res  = r_read_res;
        n_done      = 1'b0;
        n_rej       = 1'b0;
        w_fin       = 1'b0;

        if (w_adv) begin
            if (r_in_kind == i2cmbs_pkg::KIND_CMD) begin
                if (r_busy) begin
                    n_rej = 1'b1;
                end else if (r_in_op <= i2cmbs_pkg::OP_ACK) begin
                    // Opening drive changes of a command.
                    n_phase     = i2cmbs_pkg::PH_0;
                    n_bit_idx   = '0;
                    n_sub       = '0;
                    n_active_op = r_in_op;
                    n_busy      = 1'b1;
                    case (i2cmbs_pkg::t_op'(r_in_op))
                        i2cmbs_pkg::OP_INIT: begin
                            n_scl     = 1'b0;
                            n_sda     = 1'b1;
                            n_us_left = i2cmbs_pkg::DLY_INIT;
                        end
                        i2cmbs_pkg::OP_START: begin
                            n_sda     = 1'b1;
                            n_us_left = i2cmbs_pkg::DLY_1;
                        end
                        i2cmbs_pkg::OP_STOP: begin
                            n_sda     = 1'b0;
                            n_us_left = i2cmbs_pkg::DLY_1;
                        end
                        i2cmbs_pkg::OP_WRITE: begin
                            n_shift   = r_in_tx;
                            n_sda     = r_in_tx[7];
                            n_us_left = i2cmbs_pkg::DLY_1;
                        end
                        i2cmbs_pkg::OP_READ: begin
                            n_sda     = 1'b1;
                            n_shift   = '0;
                            n_us_left = i2cmbs_pkg::DLY_1;
                        end
                        default: begin
                            n_sda     = r_in_ack;
                            n_us_left = i2cmbs_pkg::DLY_3;
                        end
                    endcase
                end
            end else if (r_busy) begin
                // A tick: count toward one microsecond.
                n_sub = w_sub_inc;
                if (w_sub_inc >= w_rate || w_sub_inc == 8'd0) begin
                    n_sub     = '0;
                    n_us_left = w_us_dec;
                    if (w_us_dec == '0) begin
                        // End of the current phase.
                        case (r_active_op)
                            i2cmbs_pkg::OP_START: begin
                                case (r_phase)
                                    i2cmbs_pkg::PH_0: begin
                                        n_scl = 1'b1; n_phase = i2cmbs_pkg::PH_1;
                                        n_us_left = i2cmbs_pkg::DLY_5;
                                    end
                                    i2cmbs_pkg::PH_1: begin
                                        n_sda = 1'b0; n_phase = i2cmbs_pkg::PH_2;
                                        n_us_left = i2cmbs_pkg::DLY_5;
                                    end
                                    i2cmbs_pkg::PH_2: begin
                                        n_scl = 1'b0; n_phase = i2cmbs_pkg::PH_3;
                                        n_us_left = i2cmbs_pkg::DLY_2;
                                    end
                                    default: w_fin = 1'b1;
                                endcase
                            end
                            i2cmbs_pkg::OP_STOP: begin
                                case (r_phase)
                                    i2cmbs_pkg::PH_0: begin
                                        n_scl = 1'b1; n_phase = i2cmbs_pkg::PH_1;
                                        n_us_left = i2cmbs_pkg::DLY_5;
                                    end
                                    i2cmbs_pkg::PH_1: begin
                                        n_sda = 1'b1; n_phase = i2cmbs_pkg::PH_2;
                                        n_us_left = i2cmbs_pkg::DLY_4;
                                    end
                                    default: w_fin = 1'b1;
                                endcase
                            end
                            i2cmbs_pkg::OP_WRITE: begin
                                case (r_phase)
                                    i2cmbs_pkg::PH_0: begin
                                        n_scl = 1'b1; n_phase = i2cmbs_pkg::PH_1;
                                        n_us_left = i2cmbs_pkg::DLY_5;
                                    end
                                    i2cmbs_pkg::PH_1: begin
                                        n_scl = 1'b0;
                                        if (r_bit_idx < i2cmbs_pkg::LAST_BIT) begin
                                            // Next data bit goes out with SCL low.
                                            n_bit_idx = r_bit_idx + BIT_W'(1);
                                            n_shift   = w_shift_up;
                                            n_sda     = w_shift_up[7];
                                            n_phase   = i2cmbs_pkg::PH_0;
                                            n_us_left = i2cmbs_pkg::DLY_1;
                                        end else begin
                                            n_phase   = i2cmbs_pkg::PH_2;
                                            n_us_left = i2cmbs_pkg::DLY_2;
                                        end
                                    end
                                    i2cmbs_pkg::PH_2: begin
                                        n_sda = 1'b1; n_phase = i2cmbs_pkg::PH_3;
                                        n_us_left = i2cmbs_pkg::DLY_2;
                                    end
                                    i2cmbs_pkg::PH_3: begin
                                        n_scl = 1'b1; n_phase = i2cmbs_pkg::PH_4;
                                        n_us_left = i2cmbs_pkg::DLY_5;
                                    end
                                    i2cmbs_pkg::PH_4: begin
                                        // Slave acknowledges by holding SDA low.
                                        n_ack_flag = !r_in_sda;
                                        n_scl      = 1'b0;
                                        n_phase    = i2cmbs_pkg::PH_5;
                                        n_us_left  = i2cmbs_pkg::DLY_2;
                                    end
                                    default: w_fin = 1'b1;
                                endcase
                            end
                            i2cmbs_pkg::OP_READ: begin
                                case (r_phase)
                                    i2cmbs_pkg::PH_0: begin
                                        n_scl = 1'b0; n_phase = i2cmbs_pkg::PH_1;
                                        n_us_left = i2cmbs_pkg::DLY_5;
                                    end
                                    i2cmbs_pkg::PH_1: begin
                                        n_scl = 1'b1; n_phase = i2cmbs_pkg::PH_2;
                                        n_us_left = i2cmbs_pkg::DLY_3;
                                    end
                                    i2cmbs_pkg::PH_2: begin
                                        n_shift   = {r_shift[6:0], r_in_sda};
                                        n_phase   = i2cmbs_pkg::PH_3;
                                        n_us_left = i2cmbs_pkg::DLY_2;
                                    end
                                    i2cmbs_pkg::PH_3: begin
                                        if (r_bit_idx < i2cmbs_pkg::LAST_BIT) begin
                                            n_bit_idx = r_bit_idx + BIT_W'(1);
                                            n_phase   = i2cmbs_pkg::PH_0;
                                            n_us_left = i2cmbs_pkg::DLY_1;
                                        end else begin
                                            n_scl     = 1'b0;
                                            n_phase   = i2cmbs_pkg::PH_4;
                                            n_us_left = i2cmbs_pkg::DLY_2;
                                        end
                                    end
                                    default: begin
                                        n_read_res = r_shift;
                                        w_fin      = 1'b1;
                                    end
                                endcase
                            end
                            i2cmbs_pkg::OP_ACK: begin
                                case (r_phase)
                                    i2cmbs_pkg::PH_0: begin
                                        n_scl = 1'b1; n_phase = i2cmbs_pkg::PH_1;
                                        n_us_left = i2cmbs_pkg::DLY_5;
                                    end
                                    i2cmbs_pkg::PH_1: begin
                                        n_scl = 1'b0; n_phase = i2cmbs_pkg::PH_2;
                                        n_us_left = i2cmbs_pkg::DLY_2;
                                    end
                                    default: w_fin = 1'b1;
                                endcase
                            end
                            default: w_fin = 1'b1;
                        endcase

                        // Command complete.
                        if (w_fin) begin
                            n_busy  = 1'b0;
                            n_phase = i2cmbs_pkg::PH_0;
                            n_done  = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Sequencer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_op <= '0;
            r_phase     <= i2cmbs_pkg::PH_0;
            r_bit_idx   <= '0;
            r_shift     <= '0;
            r_us_left   <= '0;
            r_sub       <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_busy      <= 1'b0;
            r_ack_flag  <= 1'b0;
            r_read_res  <= '0;
        end else begin
            r_active_op <= n_active_op;
            r_phase     <= n_phase;
            r_bit_idx   <= n_bit_idx;
            r_shift     <= n_shift;
            r_us_left   <= n_us_left;
            r_sub       <= n_sub;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_busy      <= n_busy;
            r_ack_flag  <= n_ack_flag;
            r_read_res  <= n_read_res;
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Per-request flags of the result; the rest of the result is the live state.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res_done <= n_done;
            r_res_rej  <= n_rej;
        end
    end

    // The state only changes on w_adv, so it stays with the held result.
    assign o_out_valid    = r_out_valid;
    assign o_scl_level    = r_scl;
    assign o_sda_level    = r_sda;
    assign o_busy_res     = r_busy;
    assign o_done_res     = r_res_done;
    assign o_ack_received = r_ack_flag;
    assign o_rx_byte      = r_read_res;
    assign o_rejected     = r_res_rej;

    // A rejected command leaves the sequencer busy.
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res_rej) |-> r_busy)
        else $error("rejected result while sequencer idle");

    // A finished command leaves the sequencer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res_done) |-> !r_busy)
        else $error("done result while sequencer busy");

    // Only a command taken from the input register starts a sequence.
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(w_adv && (r_in_kind == i2cmbs_pkg::KIND_CMD)))
        else $error("sequencer became busy without a command");

    // No delay is pending while idle.
    a_idle_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_us_left == '0))
        else $error("delay pending while idle");

endmodule
